/* rtl/core/assert_macros.svh */
// Assertion macros used by the resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/core/mpr_pkg.sv */
// Package with the word types, codes and sizes of the multinomial resampler.
package mpr_pkg;

    localparam int PARTICLES = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = $clog2(PARTICLES + 1);
    localparam int SUM_W     = 22;
    localparam int PICK_W    = 7;
    localparam int TOL_W     = 16;

    localparam logic [SUM_W-1:0]  ONE_Q16  = SUM_W'(65536);
    localparam logic [PICK_W-1:0] PICK_MAX = '1;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_DRAW = 2'd1,
        OP_EMIT = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] weight;
        logic [15:0] draw;
    } cmd_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] chosen_index;
        logic             chosen_valid;
        logic             sum_error;
        logic             last;
    } result_word_t;

endpackage

/* rtl/core/multinomial_particle_resampler_core.sv */
// Multinomial resampler core: microcoded sequencer over running-sum and pick-count memories.
// A load word runs a single load step; a draw word runs an init step, k <= 7 binary-search
// probes and, on a match, a pick-count update; an emit word scans every index, then flushes.
// Throughput is one word at a time; each search probe waits on the registered read of the
// single running-sum port. Results leave on a one-cycle strobe that the receiver must take.
// Reset clears counters, pick-count valid bits and the sequencer; the tolerance register resets to 7.
module multinomial_particle_resampler_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mpr_pkg::cmd_word_t    cmd,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,
    output logic                  strobe,
    output mpr_pkg::result_word_t result
);
    import mpr_pkg::*;

    // Actions that a control word asks of the datapath.
    typedef enum logic [3:0] {
        A_NOP,
        A_LOAD,
        A_DRAW_INIT,
        A_SRCH_RD,
        A_SRCH_CMP,
        A_PICK_RD,
        A_PICK_WR,
        A_EMIT_INIT,
        A_CNT_RD,
        A_CNT_LD,
        A_EMIT_ONE,
        A_IDX_INC,
        A_FLUSH
    } act_t;

    // Jump conditions. C_NEXT never jumps, C_ALWAYS always does.
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_DRAW_FULL,
        C_SRCH_DONE,
        C_NOMATCH,
        C_CNT_NZ,
        C_IDX_MORE
    } cond_t;

    typedef logic [3:0] upc_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        upc_t  target;
    } uword_t;

    // Entry points and jump targets of the microprogram.
    localparam upc_t ST_IDLE     = 4'd0;
    localparam upc_t ST_LOAD     = 4'd1;
    localparam upc_t ST_DRAW     = 4'd2;
    localparam upc_t ST_SRCH     = 4'd3;
    localparam upc_t ST_PICK     = 4'd6;
    localparam upc_t ST_PICK_WR  = 4'd7;
    localparam upc_t ST_EMIT     = 4'd8;
    localparam upc_t ST_CNT_RD   = 4'd9;
    localparam upc_t ST_EMIT_ONE = 4'd11;

    // The microprogram. A search probe is steps 3-5: step 3 leaves when the
    // window is empty, step 4 reads the middle entry, step 5 narrows the window.
    // The emit scan reads one pick count per index (steps 9-10), sends one word
    // per pick (step 11) and moves on (step 12). Step 13 sends the final word.
    function automatic uword_t ucode_rom(input upc_t addr);
        uword_t w;
        begin
            unique case (addr)
                4'd0:    w = '{A_NOP,       C_ALWAYS,    ST_IDLE};
                4'd1:    w = '{A_LOAD,      C_ALWAYS,    ST_IDLE};
                4'd2:    w = '{A_DRAW_INIT, C_DRAW_FULL, ST_IDLE};
                4'd3:    w = '{A_NOP,       C_SRCH_DONE, ST_PICK};
                4'd4:    w = '{A_SRCH_RD,   C_NEXT,      ST_IDLE};
                4'd5:    w = '{A_SRCH_CMP,  C_ALWAYS,    ST_SRCH};
                4'd6:    w = '{A_PICK_RD,   C_NOMATCH,   ST_IDLE};
                4'd7:    w = '{A_PICK_WR,   C_ALWAYS,    ST_IDLE};
                4'd8:    w = '{A_EMIT_INIT, C_NEXT,      ST_IDLE};
                4'd9:    w = '{A_CNT_RD,    C_NEXT,      ST_IDLE};
                4'd10:   w = '{A_CNT_LD,    C_NEXT,      ST_IDLE};
                4'd11:   w = '{A_EMIT_ONE,  C_CNT_NZ,    ST_EMIT_ONE};
                4'd12:   w = '{A_IDX_INC,   C_IDX_MORE,  ST_CNT_RD};
                4'd13:   w = '{A_FLUSH,     C_ALWAYS,    ST_IDLE};
                default: w = '{A_NOP,       C_ALWAYS,    ST_IDLE};
            endcase
            return w;
        end
    endfunction

    // Memories: running sums (written below the load count only) and pick counts.
    logic [SUM_W-1:0]  sum_mem  [PARTICLES];
    logic [PICK_W-1:0] pick_mem [PARTICLES];

    // Sequencer and control state.
    upc_t              upc_reg, upc_next;
    logic [15:0]       tol_reg;
    logic [CNT_W-1:0]  wl_reg, wl_next;
    logic [CNT_W-1:0]  draws_reg, draws_next;
    logic [SUM_W-1:0]  total_reg, total_next;
    logic [PARTICLES-1:0] pick_vld_reg, pick_vld_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PICK_W-1:0] cnt_reg, cnt_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              err_reg, err_next;
    logic              strobe_reg, strobe_next;
    result_word_t      result_reg, result_next;

    // Payload registers, no reset.
    logic [15:0]       draw_reg, draw_next;
    logic [15:0]       weight_reg, weight_next;

    // Memory ports.
    logic              sum_we;
    logic [IDX_W-1:0]  sum_waddr;
    logic [SUM_W-1:0]  sum_wdata;
    logic [SUM_W-1:0]  sum_rdata_reg;
    logic              pick_we;
    logic [IDX_W-1:0]  pick_waddr;
    logic [PICK_W-1:0] pick_wdata;
    logic [IDX_W-1:0]  pick_raddr;
    logic [PICK_W-1:0] pick_rdata_reg;
    logic              pick_hit_reg;

    uword_t            uw;
    logic              jump;
    logic [CNT_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid;
    logic [SUM_W-1:0]  new_sum;
    logic [SUM_W-1:0]  dev;
    logic [PICK_W-1:0] pick_cur;

    assign uw      = ucode_rom(upc_reg);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IDX_W:1];
    assign new_sum = total_reg + SUM_W'(weight_reg);
    assign dev     = (total_reg >= ONE_Q16) ? (total_reg - ONE_Q16) : (ONE_Q16 - total_reg);
    assign pick_cur = pick_hit_reg ? pick_rdata_reg : '0;

    // The pick-count read serves the draw update and the emit scan.
    assign pick_raddr = (uw.act == A_PICK_RD) ? lo_reg[IDX_W-1:0] : idx_reg;

    always_comb
    begin
        unique case (uw.cond)
            C_NEXT:      jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_DRAW_FULL: jump = (draws_reg >= CNT_W'(PARTICLES));
            C_SRCH_DONE: jump = (lo_reg >= hi_reg);
            C_NOMATCH:   jump = (lo_reg == wl_reg);
            C_CNT_NZ:    jump = (cnt_reg != '0);
            C_IDX_MORE:  jump = (idx_reg != IDX_W'(PARTICLES - 1));
            default:     jump = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next      = upc_reg;
        wl_next       = wl_reg;
        draws_next    = draws_reg;
        total_next    = total_reg;
        pick_vld_next = pick_vld_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        err_next      = err_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        draw_next     = draw_reg;
        weight_next   = weight_reg;
        sum_we        = 1'b0;
        sum_waddr     = wl_reg[IDX_W-1:0];
        sum_wdata     = new_sum;
        pick_we       = 1'b0;
        pick_waddr    = lo_reg[IDX_W-1:0];
        pick_wdata    = (pick_cur == PICK_MAX) ? PICK_MAX : pick_cur + PICK_W'(1);

        // Sequencing: dispatch on the operation when idle, else step or jump.
        if (upc_reg == ST_IDLE) begin
            if (start) begin
                draw_next   = cmd.draw;
                weight_next = cmd.weight;
                unique case (cmd.operation)
                    OP_LOAD: upc_next = ST_LOAD;
                    OP_DRAW: upc_next = ST_DRAW;
                    OP_EMIT: upc_next = ST_EMIT;
                    default: upc_next = ST_IDLE;
                endcase
            end
        end else begin
            upc_next = jump ? uw.target : upc_reg + upc_t'(1);
        end

        unique case (uw.act)
            A_NOP: ;
            A_LOAD: begin
                // Weights past the particle count are dropped.
                if (wl_reg < CNT_W'(PARTICLES)) begin
                    sum_we     = 1'b1;
                    total_next = new_sum;
                    wl_next    = wl_reg + CNT_W'(1);
                end
            end
            A_DRAW_INIT: begin
                lo_next = '0;
                hi_next = wl_reg;
                if (draws_reg < CNT_W'(PARTICLES)) begin
                    draws_next = draws_reg + CNT_W'(1);
                end
            end
            A_SRCH_RD: ;
            A_SRCH_CMP: begin
                // Sums never decrease, so the first entry above the draw
                // lies at mid or below when the probe exceeds the draw.
                if (sum_rdata_reg > SUM_W'(draw_reg)) begin
                    hi_next = CNT_W'(mid);
                end else begin
                    lo_next = CNT_W'(mid) + CNT_W'(1);
                end
            end
            A_PICK_RD: ;
            A_PICK_WR: begin
                pick_we                               = 1'b1;
                pick_vld_next[lo_reg[IDX_W-1:0]]      = 1'b1;
            end
            A_EMIT_INIT: begin
                err_next      = (dev > SUM_W'(tol_reg));
                idx_next      = '0;
                pend_vld_next = 1'b0;
            end
            A_CNT_RD: ;
            A_CNT_LD: begin
                cnt_next = pick_cur;
            end
            A_EMIT_ONE: begin
                // One word is held back so that the final one can carry last.
                if (cnt_reg != '0) begin
                    cnt_next      = cnt_reg - PICK_W'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = idx_reg;
                    if (pend_vld_reg) begin
                        strobe_next = 1'b1;
                        result_next = '{pend_idx_reg, 1'b1, err_reg, 1'b0};
                    end
                end
            end
            A_IDX_INC: begin
                idx_next = idx_reg + IDX_W'(1);
            end
            A_FLUSH: begin
                strobe_next   = 1'b1;
                result_next   = pend_vld_reg ? result_word_t'{pend_idx_reg, 1'b1, err_reg, 1'b1}
                                             : result_word_t'{'0, 1'b0, err_reg, 1'b1};
                pend_vld_next = 1'b0;
                pick_vld_next = '0;
                wl_next       = '0;
                draws_next    = '0;
                total_next    = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            upc_reg      <= ST_IDLE;
            tol_reg      <= 16'd7;
            wl_reg       <= '0;
            draws_reg    <= '0;
            total_reg    <= '0;
            pick_vld_reg <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            pend_idx_reg <= '0;
            err_reg      <= 1'b0;
            strobe_reg   <= 1'b0;
            result_reg   <= '0;
        end else begin
            upc_reg      <= upc_next;
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
            wl_reg       <= wl_next;
            draws_reg    <= draws_next;
            total_reg    <= total_next;
            pick_vld_reg <= pick_vld_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
            pend_idx_reg <= pend_idx_next;
            err_reg      <= err_next;
            strobe_reg   <= strobe_next;
            result_reg   <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        draw_reg   <= draw_next;
        weight_reg <= weight_next;
    end

    // Running-sum memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_rdata_reg <= sum_mem[mid];
    end

    // Pick-count memory; entries without a valid bit read as zero.
    always_ff @(posedge clk)
    begin
        if (pick_we) begin
            pick_mem[pick_waddr] <= pick_wdata;
        end
        pick_rdata_reg <= pick_mem[pick_raddr];
        pick_hit_reg   <= pick_vld_reg[pick_raddr];
    end

    assign busy   = (upc_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    `include "assert_macros.svh"

    // The final word of an emit goes out while the sequencer is idle.
    `ASSERT_NOW(a_last_ends_emit, strobe && result.last, !busy)
    // A word without a real index can only be the final one.
    `ASSERT_NOW(a_empty_is_last, strobe && !result.chosen_valid, result.last)
    // A pick count is only ever bumped for a loaded entry.
    `ASSERT_NOW(a_pick_in_range, upc_reg == ST_PICK_WR, lo_reg < wl_reg)
    // A load word finishes in a single busy cycle.
    `ASSERT_NEXT(a_load_short, start && !busy && cmd.operation == OP_LOAD, busy ##1 !busy)

endmodule
